// File: hdl/lgcs_pkg.sv
// Package for the label group counting sort unit.
// Holds the sizes, the op codes and the item types; no dependencies.
package lgcs_pkg;

   localparam int MAX_ITEMS  = 1024;
   localparam int MAX_GROUPS = 256;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int GRP_W = $clog2(MAX_GROUPS);
   localparam int LBL_W = $clog2(MAX_GROUPS + 1);

   localparam logic [1:0] OP_LOAD      = 2'd0;
   localparam logic [1:0] OP_READ_POS  = 2'd1;
   localparam logic [1:0] OP_READ_GRP  = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] label;
      logic               last;
      logic [9:0]         position;
      logic [7:0]         group;
   } req_payload_type;

   typedef struct packed {
      logic [10:0] item_index;
      logic [10:0] group_begin;
      logic [10:0] group_end;
      logic [10:0] kept_count;
      logic        overflow;
   } rsp_payload_type;

endpackage

// File: hdl/lgcs_channels.sv
// Valid/ready channel interfaces for request and response items.
// Depends on lgcs_pkg for the payload types.
interface lgcs_req_if;
   import lgcs_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lgcs_rsp_if;
   import lgcs_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/label_group_counting_sort_unit.sv
// Label group counting sort: loads labels, sorts positions by group, answers queries.
// Depends on lgcs_pkg and the channel interfaces in lgcs_channels.sv.
// Load without last: the label is stored if there is room; no result is given.
// Query: the result is registered from ST_QRY; the next item is taken once back in ST_IDLE.
// Load with last: the unit clears all MAX_GROUPS cursor and start entries, counts the kept
// labels, forms the prefix over the active groups, scatters the kept positions, then answers.
// One item at a time; a new item is taken while a result waits if it is being taken.
// Reset is synchronous: control state and num_groups (256) clear; memories are not swept.
module label_group_counting_sort_unit (
   input  logic       clock,
   input  logic       reset,
   lgcs_req_if.sink   req_chan,
   lgcs_rsp_if.source rsp_chan,
   input  logic       csr_write_en,
   input  logic [8:0] csr_write_data
);
   import lgcs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLR, ST_CNT_RD, ST_CNT_LBL, ST_CNT_UPD, ST_PFX_RD, ST_PFX_WR,
      ST_SCT_RD, ST_SCT_LBL, ST_SCT_UPD, ST_FINISH, ST_QRY
   } state_type;

   logic [LBL_W-1:0] label_store  [MAX_ITEMS];
   logic [CNT_W-1:0] cursor_mem   [MAX_GROUPS];
   logic [CNT_W-1:0] start_mem    [MAX_GROUPS];
   logic [CNT_W-1:0] sorted_store [MAX_ITEMS];

   state_type        state_ff, state_in;
   logic [8:0]       num_groups_ff;
   logic [CNT_W-1:0] load_count_ff, load_count_in;
   logic             overflow_seen_ff, overflow_seen_in;
   logic             batch_open_ff, batch_open_in;
   logic [CNT_W-1:0] kept_total_ff, kept_total_in;
   logic             done_ovf_ff, done_ovf_in;
   logic             sorted_once_ff, sorted_once_in;
   logic [LBL_W-1:0] sort_k_ff, sort_k_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [LBL_W-1:0] grp_ff, grp_in;
   logic [GRP_W-1:0] g_ff, g_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic             q_pos_ff, q_pos_in;
   logic             q_ok_ff, q_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic [LBL_W-1:0] lbl_rdata_ff;
   logic [CNT_W-1:0] cur_rdata_ff, start_rdata_ff, srt_rdata_ff;

   logic             lbl_we, cur_we, start_we, srt_we;
   logic [IDX_W-1:0] lbl_waddr, lbl_raddr, srt_waddr;
   logic [LBL_W-1:0] lbl_wdata;
   logic [GRP_W-1:0] cur_waddr, cur_raddr, start_waddr;
   logic [CNT_W-1:0] cur_wdata, start_wdata, srt_wdata;

   logic             accept;
   logic [LBL_W-1:0] k_now;
   logic [CNT_W-1:0] cnt_eff;
   logic             lbl_in_range;

   assign k_now = (num_groups_ff > LBL_W'(MAX_GROUPS)) ? LBL_W'(MAX_GROUPS) : num_groups_ff;
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
   assign cnt_eff = batch_open_ff ? load_count_ff : '0;
   assign lbl_in_range = $unsigned(req_chan.payload.label) < 32'(MAX_GROUPS);
   assign lbl_raddr = idx_ff[IDX_W-1:0];

   always_comb begin
      state_in         = state_ff;
      load_count_in    = load_count_ff;
      overflow_seen_in = overflow_seen_ff;
      batch_open_in    = batch_open_ff;
      kept_total_in    = kept_total_ff;
      done_ovf_in      = done_ovf_ff;
      sorted_once_in   = sorted_once_ff;
      sort_k_in        = sort_k_ff;
      idx_in           = idx_ff;
      grp_in           = grp_ff;
      g_in             = g_ff;
      run_in           = run_ff;
      q_pos_in         = q_pos_ff;
      q_ok_in          = q_ok_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in      = rsp_data_ff;
      lbl_we      = 1'b0;
      lbl_waddr   = cnt_eff[IDX_W-1:0];
      lbl_wdata   = lbl_in_range ? LBL_W'(req_chan.payload.label[GRP_W-1:0])
                                 : LBL_W'(MAX_GROUPS);
      cur_we      = 1'b0;
      cur_waddr   = g_ff;
      cur_wdata   = cur_rdata_ff + CNT_W'(1);
      cur_raddr   = req_chan.payload.group;
      start_we    = 1'b0;
      start_waddr = grp_ff[GRP_W-1:0];
      start_wdata = run_ff;
      srt_we      = 1'b0;
      srt_waddr   = cur_rdata_ff[IDX_W-1:0];
      srt_wdata   = idx_ff + CNT_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.payload.op)
                  OP_LOAD: begin
                     batch_open_in = 1'b1;
                     overflow_seen_in = batch_open_ff ? overflow_seen_ff : 1'b0;
                     load_count_in = cnt_eff;
                     if (cnt_eff < CNT_W'(MAX_ITEMS)) begin
                        lbl_we = 1'b1;
                        load_count_in = cnt_eff + CNT_W'(1);
                     end else begin
                        overflow_seen_in = 1'b1;
                     end
                     if (req_chan.payload.last) begin
                        sort_k_in = k_now;
                        grp_in    = '0;
                        state_in  = ST_CLR;
                     end
                  end
                  OP_READ_POS: begin
                     q_pos_in = 1'b1;
                     q_ok_in  = CNT_W'(req_chan.payload.position) < kept_total_ff;
                     state_in = ST_QRY;
                  end
                  OP_READ_GRP: begin
                     q_pos_in = 1'b0;
                     q_ok_in  = sorted_once_ff &&
                                (LBL_W'(req_chan.payload.group) < k_now);
                     state_in = ST_QRY;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLR: begin
            cur_we    = 1'b1;
            cur_waddr = grp_ff[GRP_W-1:0];
            cur_wdata = '0;
            start_we  = 1'b1;
            start_wdata = '0;
            grp_in    = grp_ff + LBL_W'(1);
            if (grp_ff == LBL_W'(MAX_GROUPS - 1)) begin
               idx_in   = '0;
               state_in = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            if (idx_ff == load_count_ff) begin
               grp_in   = '0;
               run_in   = '0;
               state_in = ST_PFX_RD;
            end else begin
               state_in = ST_CNT_LBL;
            end
         end
         ST_CNT_LBL: begin
            cur_raddr = lbl_rdata_ff[GRP_W-1:0];
            g_in      = lbl_rdata_ff[GRP_W-1:0];
            if (lbl_rdata_ff < sort_k_ff) begin
               state_in = ST_CNT_UPD;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_CNT_RD;
            end
         end
         ST_CNT_UPD: begin
            cur_we   = 1'b1;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_CNT_RD;
         end
         ST_PFX_RD: begin
            cur_raddr = grp_ff[GRP_W-1:0];
            if (grp_ff == sort_k_ff) begin
               idx_in   = '0;
               state_in = ST_SCT_RD;
            end else begin
               state_in = ST_PFX_WR;
            end
         end
         ST_PFX_WR: begin
            start_we  = 1'b1;
            cur_we    = 1'b1;
            cur_waddr = grp_ff[GRP_W-1:0];
            cur_wdata = run_ff;
            run_in    = run_ff + cur_rdata_ff;
            grp_in    = grp_ff + LBL_W'(1);
            state_in  = ST_PFX_RD;
         end
         ST_SCT_RD: begin
            state_in = (idx_ff == load_count_ff) ? ST_FINISH : ST_SCT_LBL;
         end
         ST_SCT_LBL: begin
            cur_raddr = lbl_rdata_ff[GRP_W-1:0];
            g_in      = lbl_rdata_ff[GRP_W-1:0];
            if (lbl_rdata_ff < sort_k_ff) begin
               state_in = ST_SCT_UPD;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SCT_RD;
            end
         end
         ST_SCT_UPD: begin
            srt_we   = 1'b1;
            cur_we   = 1'b1;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_SCT_RD;
         end
         ST_FINISH: begin
            kept_total_in  = run_ff;
            done_ovf_in    = overflow_seen_ff;
            batch_open_in  = 1'b0;
            sorted_once_in = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_data_in    = '{item_index: '0, group_begin: '0, group_end: '0,
                               kept_count: run_ff, overflow: overflow_seen_ff};
            state_in       = ST_IDLE;
         end
         ST_QRY: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{item_index: '0, group_begin: '0, group_end: '0,
                             kept_count: kept_total_ff, overflow: done_ovf_ff};
            if (q_ok_ff) begin
               if (q_pos_ff) begin
                  rsp_data_in.item_index = srt_rdata_ff;
               end else begin
                  rsp_data_in.group_begin = start_rdata_ff;
                  rsp_data_in.group_end   = cur_rdata_ff;
               end
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         num_groups_ff    <= 9'(MAX_GROUPS);
         load_count_ff    <= '0;
         overflow_seen_ff <= 1'b0;
         batch_open_ff    <= 1'b0;
         kept_total_ff    <= '0;
         done_ovf_ff      <= 1'b0;
         sorted_once_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         if (csr_write_en) begin
            num_groups_ff <= csr_write_data;
         end
         load_count_ff    <= load_count_in;
         overflow_seen_ff <= overflow_seen_in;
         batch_open_ff    <= batch_open_in;
         kept_total_ff    <= kept_total_in;
         done_ovf_ff      <= done_ovf_in;
         sorted_once_ff   <= sorted_once_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      sort_k_ff   <= sort_k_in;
      idx_ff      <= idx_in;
      grp_ff      <= grp_in;
      g_ff        <= g_in;
      run_ff      <= run_in;
      q_pos_ff    <= q_pos_in;
      q_ok_ff     <= q_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         label_store[lbl_waddr] <= lbl_wdata;
      end
      lbl_rdata_ff <= label_store[lbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cursor_mem[cur_waddr] <= cur_wdata;
      end
      cur_rdata_ff <= cursor_mem[cur_raddr];
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[start_waddr] <= start_wdata;
      end
      start_rdata_ff <= start_mem[req_chan.payload.group];
   end

   always_ff @(posedge clock) begin
      if (srt_we) begin
         sorted_store[srt_waddr] <= srt_wdata;
      end
      srt_rdata_ff <= sorted_store[req_chan.payload.position];
   end

endmodule

// File: verif/tb_label_group_counting_sort_unit.sv
`timescale 1ns / 1ps
// Testbench for label_group_counting_sort_unit: directed and random label batches and queries,
// checked against an in-bench counting sort model. Uses lgcs_pkg and lgcs_channels.sv.
module tb_label_group_counting_sort_unit;
   import lgcs_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         STALL_LIMIT = 30000;
   localparam int         CSR_HOLDOFF = 8;
   localparam int         END_TAIL    = 20;
   localparam int         PHASE_ITEMS = 56;

   class sorted_group_tracker;
      logic [8:0]      num_groups;
      logic [8:0]      label_mem [MAX_ITEMS];
      logic [10:0]     grp_begin [MAX_GROUPS];
      logic [10:0]     grp_end [MAX_GROUPS];
      logic [10:0]     sorted_slot [MAX_ITEMS];
      int unsigned     load_cnt;
      bit              load_ovf;
      logic [10:0]     kept_total;
      bit              sorted_ovf;
      bit              batch_open;
      rsp_payload_type pending_answers [$];
      int              errors;
      int              checked;
      int              sorts;

      function new();
         int i;
         num_groups = 9'd256;
         for (i = 0; i < MAX_ITEMS; i++) begin
            label_mem[i] = '0;
            sorted_slot[i] = '0;
         end
         for (i = 0; i < MAX_GROUPS; i++) begin
            grp_begin[i] = '0;
            grp_end[i] = '0;
         end
         load_cnt = 0;
         load_ovf = 1'b0;
         kept_total = '0;
         sorted_ovf = 1'b0;
         batch_open = 1'b0;
         errors = 0;
         checked = 0;
         sorts = 0;
      endfunction

      function int active_groups();
         return (num_groups > MAX_GROUPS) ? MAX_GROUPS : int'(num_groups);
      endfunction

      function void set_groups(logic [8:0] value);
         num_groups = value;
      endfunction

      function int waiting();
         return pending_answers.size();
      endfunction

      function void sort_batch();
         int unsigned i;
         int unsigned g;
         int unsigned k;
         int unsigned run;
         int unsigned slot;
         k = active_groups();
         run = 0;
         for (g = 0; g < MAX_GROUPS; g++) begin
            grp_begin[g] = '0;
            grp_end[g] = '0;
         end
         for (i = 0; i < load_cnt; i++) begin
            if (label_mem[i] < k) grp_end[label_mem[i]]++;
         end
         for (g = 0; g < k; g++) begin
            grp_begin[g] = 11'(run);
            run += grp_end[g];
            grp_end[g] = grp_begin[g];
         end
         for (i = 0; i < load_cnt; i++) begin
            g = 32'(label_mem[i]);
            if (g < k) begin
               slot = 32'(grp_end[g]);
               sorted_slot[slot] = 11'(i + 1);
               grp_end[g] = 11'(slot + 1);
            end
         end
         kept_total = 11'(run);
         sorted_ovf = load_ovf;
         batch_open = 1'b0;
         sorts++;
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type a;
         a = '0;
         case (r.op)
            OP_LOAD: begin
               if (!batch_open) begin
                  load_cnt = 0;
                  load_ovf = 1'b0;
                  batch_open = 1'b1;
               end
               if (load_cnt < MAX_ITEMS) begin
                  label_mem[load_cnt] = (r.label >= 0 && r.label < MAX_GROUPS) ?
                                        r.label[8:0] : 9'(MAX_GROUPS);
                  load_cnt++;
               end else begin
                  load_ovf = 1'b1;
               end
               if (!r.last) return;
               sort_batch();
            end
            OP_READ_POS: begin
               if (r.position < kept_total) a.item_index = sorted_slot[r.position];
            end
            OP_READ_GRP: begin
               if (r.group < active_groups()) begin
                  a.group_begin = grp_begin[r.group];
                  a.group_end = grp_end[r.group];
               end
            end
            default: return;
         endcase
         a.kept_count = kept_total;
         a.overflow = sorted_ovf;
         pending_answers.push_back(a);
      endfunction

      function void compare_field(string name, logic [10:0] want, logic [10:0] got);
         if (got !== want) begin
            $error("%s expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_answer(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_answers.size() == 0) begin
            $error("response item with nothing pending");
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         checked++;
         compare_field("item_index", want.item_index, got.item_index);
         compare_field("group_begin", want.group_begin, got.group_begin);
         compare_field("group_end", want.group_end, got.group_end);
         compare_field("kept_count", want.kept_count, got.kept_count);
         compare_field("overflow", 11'(want.overflow), 11'(got.overflow));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_en;
   logic [8:0] csr_write_data;
   bit         idle_on;
   int         items_sent;
   int         settings_used;

   sorted_group_tracker tracker;

   lgcs_req_if req_if();
   lgcs_rsp_if rsp_if();

   label_group_counting_sort_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic req_payload_type rand_fields();
      req_payload_type p;
      p.op = 2'($urandom);
      p.label = $urandom;
      p.last = 1'($urandom);
      p.position = 10'($urandom);
      p.group = 8'($urandom);
      return p;
   endfunction

   function automatic req_payload_type make_load(logic signed [31:0] lab, bit last);
      req_payload_type p;
      p = rand_fields();
      p.op = OP_LOAD;
      p.label = lab;
      p.last = last;
      return p;
   endfunction

   function automatic req_payload_type make_pos(int pos);
      req_payload_type p;
      p = rand_fields();
      p.op = OP_READ_POS;
      p.position = 10'(pos);
      return p;
   endfunction

   function automatic req_payload_type make_grp(int g);
      req_payload_type p;
      p = rand_fields();
      p.op = OP_READ_GRP;
      p.group = 8'(g);
      return p;
   endfunction

   function automatic logic signed [31:0] rand_label(int k);
      case ($urandom_range(0, 19))
         0: return $urandom;
         1: return -int'($urandom_range(1, 8));
         2: return MAX_GROUPS + int'($urandom_range(0, 300));
         3: return k + int'($urandom_range(0, 3));
         default: return (k == 0) ? int'($urandom_range(0, 3)) : int'($urandom_range(0, k - 1));
      endcase
   endfunction

   function automatic req_payload_type rand_query(int k);
      if ($urandom_range(0, 1) == 0) begin
         return make_pos(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_ITEMS - 1))
                                                    : int'($urandom_range(0, tracker.kept_total)));
      end
      return make_grp(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_GROUPS - 1))
                                                 : int'($urandom_range(0, k)));
   endfunction

   task automatic send_req(input req_payload_type p);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.note_request(p);
      items_sent++;
   endtask

   task automatic write_groups(input logic [8:0] value);
      req_if.valid <= 1'b0;
      while (tracker.waiting() != 0) @(posedge clock);
      repeat (CSR_HOLDOFF) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.set_groups(value);
      settings_used++;
   endtask

   task automatic run_phase(input int budget);
      int sent;
      int n;
      int i;
      int k;
      req_payload_type p;
      sent = 0;
      while (sent < budget) begin
         k = tracker.active_groups();
         if ($urandom_range(0, 9) < 8) begin
            n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(25, 120))
                                            : int'($urandom_range(1, 24));
            for (i = 1; i <= n; i++) begin
               if ($urandom_range(0, 19) == 0) begin
                  send_req(rand_query(k));
                  sent++;
               end
               send_req(make_load(rand_label(k), i == n));
               sent++;
            end
            repeat ($urandom_range(1, 12)) begin
               send_req(rand_query(k));
               sent++;
            end
         end else begin
            p = rand_fields();
            send_req(p);
            if (p.op != OP_UNUSED) sent++;
         end
      end
   endtask

   initial begin : stimulus
      logic [8:0] plan [8];
      req_payload_type p;
      int ph;
      int i;
      tracker = new();
      items_sent = 0;
      settings_used = 0;
      idle_on = 1'b1;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // queries before any sort answer zero
      send_req(make_grp(0));
      send_req(make_pos(0));
      p = rand_fields();
      p.op = OP_UNUSED;
      send_req(p);

      // in-range extremes mixed with negative and oversized labels
      send_req(make_load(0, 1'b0));
      send_req(make_load(255, 1'b0));
      send_req(make_load(-1, 1'b0));
      send_req(make_load(256, 1'b0));
      send_req(make_load(32'sh7FFF_FFFF, 1'b0));
      send_req(make_load(32'sh8000_0000, 1'b0));
      send_req(make_load(3, 1'b0));
      send_req(make_load(0, 1'b1));
      send_req(make_pos(0));
      send_req(make_pos(3));
      send_req(make_pos(4));
      send_req(make_pos(MAX_ITEMS - 1));
      send_req(make_grp(0));
      send_req(make_grp(255));
      send_req(make_grp(3));
      send_req(make_grp(1));

      // queries while a new batch is loading see the previous sort
      send_req(make_load(5, 1'b0));
      send_req(make_pos(0));
      send_req(make_grp(255));
      send_req(make_load(5, 1'b1));

      plan[0] = 9'd1;
      plan[1] = 9'd0;
      plan[2] = 9'd511;
      plan[3] = 9'd2;
      plan[4] = 9'($urandom_range(3, 255));
      plan[5] = 9'd255;
      plan[6] = 9'($urandom_range(1, 511));
      plan[7] = 9'd256;
      for (ph = 0; ph < 8; ph++) begin
         write_groups(plan[ph]);
         if (ph == 7) idle_on = 1'b0;
         if (ph == 2) begin
            // overfull batch: the last two labels, last one included, are dropped
            for (i = 0; i < MAX_ITEMS + 2; i++) begin
               send_req(make_load(int'($urandom_range(0, MAX_GROUPS - 1)), i == MAX_ITEMS + 1));
            end
            send_req(make_pos(MAX_ITEMS - 1));
            send_req(make_pos(0));
            send_req(make_grp(MAX_GROUPS - 1));
            send_req(make_grp(0));
         end
         run_phase(PHASE_ITEMS);
      end

      req_if.valid <= 1'b0;
      while (tracker.waiting() != 0) @(posedge clock);
      repeat (END_TAIL) @(posedge clock);
      $display("Ran %0d request items over %0d group settings; %0d sorts, %0d responses checked.",
               items_sent, settings_used, tracker.sorts, tracker.checked);
      if (tracker.errors == 0 && tracker.waiting() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : response_side
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         tracker.check_answer(rsp_if.payload);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
